// File: rtl/atf_pkg.sv
// package: types, constants and float helpers for the truncating affine transform
`default_nettype none
package atf_pkg;
  localparam int unsigned StoreWords = 12;
  localparam logic [30:0] InfBits = 31'h7f800000;
  localparam logic FuncLoad = 1'b0;
  localparam logic FuncXform = 1'b1;

  typedef logic [31:0] word_t;

  // product stage result handed to the add stage
  typedef struct packed {
    logic  bad;
    word_t val;
  } fres_t;

  function automatic logic is_zero(input word_t b);
    is_zero = (b[30:0] == 31'd0);
  endfunction

  function automatic logic is_norm(input word_t b);
    is_norm = (b[30:23] != 8'd0) && (b[30:23] != 8'hff);
  endfunction
endpackage
`default_nettype wire

// File: rtl/atf_mul.sv
// truncating single-precision multiply, one register stage
`default_nettype none
module atf_mul (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire atf_pkg::word_t  a_i,
  input  wire atf_pkg::word_t  b_i,
  output atf_pkg::fres_t       res_o
);
  import atf_pkg::*;
  logic [47:0] prod;
  logic [9:0]  e;
  fres_t       res_d, res_q;

  always_comb begin
    prod = {24'd0, 1'b1, a_i[22:0]} * {24'd0, 1'b1, b_i[22:0]};
    e = {2'b0, a_i[30:23]} + {2'b0, b_i[30:23]} + {9'd0, prod[47]};
    res_d.bad = 1'b0;
    res_d.val = '0;
    if (is_zero(a_i) || is_zero(b_i)) begin
      res_d.val = {a_i[31] ^ b_i[31], 31'd0};
    end else if (!is_norm(a_i) || !is_norm(b_i)) begin
      res_d.bad = 1'b1;
    end else if (e <= 10'd127 || e >= 10'd382) begin
      res_d.bad = 1'b1;
    end else begin
      res_d.val[31]    = a_i[31] ^ b_i[31];
      res_d.val[30:23] = 8'(e - 10'd127);
      res_d.val[22:0]  = prod[47] ? prod[46:24] : prod[45:23];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end
  assign res_o = res_q;
endmodule
`default_nettype wire

// File: rtl/atf_add.sv
// truncating single-precision add, one register stage
`default_nettype none
module atf_add (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire atf_pkg::fres_t  a_i,
  input  wire atf_pkg::fres_t  b_i,
  output atf_pkg::fres_t       res_o
);
  import atf_pkg::*;
  word_t       a, b, bw, sw;
  logic        sign, swap;
  logic [7:0]  gap8;
  logic [25:0] big, sml, acc;
  logic        sticky;
  logic [4:0]  lz;
  logic [25:0] nrm;
  logic [9:0]  e;
  logic [49:0] sh;
  fres_t       res_d, res_q;

  always_comb begin
    a = a_i.val;
    b = b_i.val;
    swap = !((a[30:23] > b[30:23]) || (a[30:23] == b[30:23] && a[22:0] >= b[22:0]));
    bw = swap ? b : a;
    sw = swap ? a : b;
    sign = bw[31];
    gap8 = bw[30:23] - sw[30:23];
    big = {1'b0, 1'b1, bw[22:0], 1'b0};
    // clamp keeps the hidden bit inside the sticky field for very large gaps
    sh = {1'b0, 1'b1, sw[22:0], 1'b0, 24'd0} >> ((gap8 > 8'd48) ? 8'd48 : gap8);
    sticky = (sh[23:0] != 24'd0);
    sml = sh[49:24];
    if (bw[31] == sw[31]) begin
      acc = big + sml;
    end else begin
      acc = big - sml - {25'd0, sticky};
    end
    lz = 5'd0;
    for (int i = 25; i >= 0; i--) begin
      if (acc[i] && lz == 5'd0 && i != 0) begin
        lz = 5'(25 - i);
      end
    end
    if (acc[25]) lz = 5'd0;
    nrm = acc << lz;
    e = {2'b0, bw[30:23]} + 10'd1 - {5'd0, lz};
    res_d.bad = a_i.bad | b_i.bad;
    res_d.val = '0;
    if ((!is_zero(a) && !is_norm(a)) || (!is_zero(b) && !is_norm(b))) begin
      res_d.bad = 1'b1;
    end else if (is_zero(a) && is_zero(b)) begin
      res_d.val = {a[31] & b[31], 31'd0};
    end else if (is_zero(a)) begin
      res_d.val = b;
    end else if (is_zero(b)) begin
      res_d.val = a;
    end else if (acc == 26'd0) begin
      res_d.val = '0;
    end else if (e[9] || e == 10'd0) begin
      res_d.val = {sign, 31'd0};
    end else if (e >= 10'd255) begin
      res_d.val = {sign, InfBits};
    end else begin
      res_d.val = {sign, e[7:0], nrm[24:2]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end
  assign res_o = res_q;
endmodule
`default_nettype wire

// File: rtl/atf_lane.sv
// one column lane: three multiplies then a chain of three adds
`default_nettype none
module atf_lane (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire atf_pkg::word_t  x_i,
  input  wire atf_pkg::word_t  y_i,
  input  wire atf_pkg::word_t  z_i,
  input  wire atf_pkg::word_t  m0_i,
  input  wire atf_pkg::word_t  m1_i,
  input  wire atf_pkg::word_t  m2_i,
  input  wire atf_pkg::word_t  t_i,
  output atf_pkg::fres_t       res_o
);
  import atf_pkg::*;
  fres_t p0, p1, p2, s0, s1, s2;
  fres_t t_q, p1_q, p2_q, p2_qq;

  atf_mul u_m0 (.clk_i, .en_i, .a_i(x_i), .b_i(m0_i), .res_o(p0));
  atf_mul u_m1 (.clk_i, .en_i, .a_i(y_i), .b_i(m1_i), .res_o(p1));
  atf_mul u_m2 (.clk_i, .en_i, .a_i(z_i), .b_i(m2_i), .res_o(p2));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q   <= '{bad: 1'b0, val: t_i};
      p1_q  <= p1;
      p2_q  <= p2;
      p2_qq <= p2_q;
    end
  end

  atf_add u_a0 (.clk_i, .en_i, .a_i(t_q), .b_i(p0), .res_o(s0));
  atf_add u_a1 (.clk_i, .en_i, .a_i(s0), .b_i(p1_q), .res_o(s1));
  atf_add u_a2 (.clk_i, .en_i, .a_i(s1), .b_i(p2_qq), .res_o(s2));
  assign res_o = s2;
endmodule
`default_nettype wire

// File: rtl/affine_transform_3d_truncating_float.sv
// top level: coefficient store, three column lanes and the merging output stage
//
// one beat in per clock while s_axis_tready is high: load beats (tuser low) write
// a coefficient word, transform beats (tuser high) carry x, y, z and yield one
// output beat. the three columns run in parallel lanes, each a multiply stage
// followed by three chained add stages; the merge stage ors the lanes' domain flags
// and zeroes the result when any is set. the pipeline advances while its last stage
// is free or being drained; a full pipeline streams one vector per clock while drained.
`default_nettype none
module affine_transform_3d_truncating_float (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: coef_index[3:0], coef_value[35:4], vec_x[67:36], vec_y[99:68], vec_z[131:100]
  input  wire logic [135:0] s_axis_tdata,
  // tuser: func
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: out_x[31:0], out_y[63:32], out_z[95:64], out_of_domain[96]
  output logic [103:0]      m_axis_tdata
);
  import atf_pkg::*;
  localparam int unsigned Depth = 4;

  word_t      store_q [StoreWords];
  logic [Depth-1:0] vld_q;
  logic       en;
  logic       acc_in;
  fres_t      r [3];
  word_t      vx, vy, vz;
  logic [3:0] cidx;

  // advance whenever the output slot is empty or being taken
  assign en = !vld_q[Depth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign cidx = s_axis_tdata[3:0];
  assign vx = s_axis_tdata[67:36];
  assign vy = s_axis_tdata[99:68];
  assign vz = s_axis_tdata[131:100];

  // coefficient store, written by load beats
  always_ff @(posedge clk_i) begin
    if (acc_in && s_axis_tuser == FuncLoad && cidx < 4'(StoreWords)) begin
      store_q[cidx] <= s_axis_tdata[35:4];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    atf_lane u_lane (
      .clk_i, .en_i(en), .x_i(vx), .y_i(vy), .z_i(vz),
      .m0_i(store_q[j]), .m1_i(store_q[3+j]), .m2_i(store_q[6+j]),
      .t_i(store_q[9+j]), .res_o(r[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], acc_in && s_axis_tuser == FuncXform};
    end
  end

  // merge stage: any lane out of domain zeroes all three columns
  logic bad;
  assign bad = r[0].bad | r[1].bad | r[2].bad;
  assign m_axis_tvalid = vld_q[Depth-1];
  assign m_axis_tdata = {7'd0, bad, bad ? 96'd0 : {r[2].val, r[1].val, r[0].val}};

  ap_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output dropped");
  ap_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("stall with empty output");
  ap_adv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == FuncXform |=> vld_q[0])
    else $error("transform beat lost");
endmodule
`default_nettype wire
